// ----- hw/rtl/strided_map_tile_checksum_defines.svh -----
// Assertion macros for the strided map tile checksum block.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef STRIDED_MAP_TILE_CHECKSUM_DEFINES_SVH
`define STRIDED_MAP_TILE_CHECKSUM_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define SMTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SMTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/smtc_pkg.sv -----
// Shared types, constants and modulo helpers for the strided map tile checksum.
// No dependencies; imported by every module of the block.
package smtc_pkg;

  localparam int MAP_SIDE = 1024;

  localparam logic [7:0] BYTE_LIMIT = 8'hA1;
  localparam logic [7:0] BYTE_SPECIAL = 8'hAB;
  localparam logic [4:0] MOD31 = 5'd31;

  // Register index of the key
  localparam logic REG_MAP_KEY = 1'b0;

  // Key register and the phases decoded from it
  typedef struct packed {
    logic [31:0] key;
    logic [4:0]  rphase;
    logic [4:0]  cphase;
    logic        bypass;
    logic        reload;
  } smtc_cfg_t;

  // Reduce a value below 63 into 0..30
  function automatic logic [4:0] fold31(input logic [5:0] s);
    logic [5:0] r;
    begin
      if (s >= 6'd62) begin
        r = s - 6'd62;
      end else if (s >= 6'(MOD31)) begin
        r = s - 6'(MOD31);
      end else begin
        r = s;
      end
      return r[4:0];
    end
  endfunction

  // Column mod 31: 32 is 1 mod 31, so add the two 5-bit digits
  function automatic logic [4:0] col_mod31(input logic [9:0] c);
    logic [5:0] s;
    begin
      s = {1'b0, c[9:5]} + {1'b0, c[4:0]};
      return fold31(s);
    end
  endfunction

  // Key mod 31: sum the 5-bit digits, fold once more, then reduce
  function automatic logic [4:0] key_mod31(input logic [31:0] k);
    logic [7:0] s;
    logic [5:0] f;
    begin
      s = {6'd0, k[31:30]};
      for (int i = 0; i < 6; i++) begin
        s = s + {3'd0, k[5*i +: 5]};
      end
      f = {3'd0, s[7:5]} + {1'b0, s[4:0]};
      return fold31(f);
    end
  endfunction

endpackage

// ----- hw/rtl/smtc_cfg_regs.sv -----
// APB-style register port holding the map key and its decoded phases.
// Depends on smtc_pkg.
module smtc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output smtc_pkg::smtc_cfg_t cfg
);
  import smtc_pkg::*;

  logic [31:0] key_r;
  logic [4:0]  rphase_r;
  logic [4:0]  cphase_r;
  logic        bypass_r;
  logic        key_wr;

  assign pready = 1'b1;
  assign key_wr = psel && penable && pwrite && (paddr[2] == REG_MAP_KEY);

  // Decode the phases once, at the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rphase_r <= '0;
      cphase_r <= '0;
      bypass_r <= 1'b0;
    end else if (key_wr) begin
      key_r    <= pwdata;
      rphase_r <= pwdata[31] ? 5'd0 : pwdata[4:0];
      cphase_r <= key_mod31(pwdata);
      // negative key with nonzero low bits puts the row phase off the map
      bypass_r <= pwdata[31] && (pwdata[4:0] != 5'd0);
    end
  end

  assign prdata = (paddr[2] == REG_MAP_KEY) ? key_r : 32'd0;

  assign cfg.key    = key_r;
  assign cfg.rphase = rphase_r;
  assign cfg.cphase = cphase_r;
  assign cfg.bypass = bypass_r;
  assign cfg.reload = key_wr;

endmodule

// ----- hw/rtl/smtc_tile_filter.sv -----
// Decides whether one tile is counted into the checksum.
// Depends on smtc_pkg.
module smtc_tile_filter (
  input  logic                tile_row_i,
  input  logic [9:0]          row,
  input  logic [9:0]          col,
  input  logic [7:0]          val,
  input  smtc_pkg::smtc_cfg_t cfg,
  output logic                counts
);
  import smtc_pkg::*;

  logic in_map;
  logic phase_hit;
  logic byte_ok;

  assign in_map    = (32'(row) < 32'(MAP_SIDE)) && (32'(col) < 32'(MAP_SIDE));
  assign phase_hit = (row[4:0] == cfg.rphase) && (col_mod31(col) == cfg.cphase);
  assign byte_ok   = (val != 8'd0) && ((val < BYTE_LIMIT) || (val == BYTE_SPECIAL));
  assign counts    = tile_row_i && !cfg.bypass && in_map && phase_hit && byte_ok;

endmodule

// ----- hw/rtl/strided_map_tile_checksum.sv -----
// Strided map tile checksum: one tile transaction per cycle in unless in_stall,
// one sum on each last tile out. A tile is captured in the input register and its
// sum lands in the output register when that stage advances; the sustained rate
// is one tile per cycle while no stalled result blocks it. The only loop is the
// 32-bit accumulate. Depends on smtc_pkg, smtc_cfg_regs, smtc_tile_filter.
`include "strided_map_tile_checksum_defines.svh"
module strided_map_tile_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_tile_row,
  input  logic [9:0]  in_tile_column,
  input  logic [7:0]  in_tile_value,
  input  logic        in_last_tile,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_map_sum
);
  import smtc_pkg::*;

  smtc_cfg_t cfg;

  logic        s1_valid_r, s1_valid_nxt;
  logic [9:0]  s1_row_r;
  logic [9:0]  s1_col_r;
  logic [7:0]  s1_val_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        in_acc;
  logic        counts;
  logic [31:0] addend;
  logic [31:0] sum_r, sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_sum_r;

  smtc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smtc_tile_filter u_filter (
    .tile_row_i (s1_valid_r),
    .row        (s1_row_r),
    .col        (s1_col_r),
    .val        (s1_val_r),
    .cfg        (cfg),
    .counts     (counts)
  );

  // Advance the input stage unless a waiting result blocks it
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Capture the incoming tile
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r  <= in_tile_row;
      s1_col_r  <= in_tile_column;
      s1_val_r  <= in_tile_value;
      s1_last_r <= in_last_tile;
    end
  end

  // Accumulate; restart at the key on a last tile or a key write
  assign addend = counts ? (cfg.key ^ {24'd0, s1_val_r}) : 32'd0;

  always_comb begin
    sum_nxt = sum_r;
    if (cfg.reload) begin
      sum_nxt = pwdata;
    end else if (s1_adv) begin
      sum_nxt = s1_last_r ? cfg.key : (sum_r + addend);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_sum_r <= sum_r + addend;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_map_sum = out_sum_r;

  // Checks
  `SMTC_ASSERT_NEXT(a_last_gives_result, s1_adv && s1_last_r, out_valid_r,
                    "last tile did not produce a result")
  `SMTC_ASSERT_NEXT(a_last_restarts_sum, s1_adv && s1_last_r && !cfg.reload,
                    sum_r == $past(cfg.key), "accumulator not restarted at key")
  `SMTC_ASSERT_SAME(a_bypass_no_count, cfg.bypass, !counts,
                    "tile counted while row phase lies off the map")
  `SMTC_ASSERT_SAME(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r,
                    "input stalled without a blocked tile")

endmodule

// ----- sim/map_sum_checker.sv -----
`timescale 1ns / 1ps
// Checker for the strided map tile checksum: watches the register, tile and sum
// transactions, predicts every map sum on its own and compares it with the block.
// Needs nothing but the port signals of strided_map_tile_checksum.
module map_sum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [9:0]  in_tile_row,
  input  logic [9:0]  in_tile_column,
  input  logic [7:0]  in_tile_value,
  input  logic        in_last_tile,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_map_sum,
  output int          fail_count,
  output int          sums_pending
);

  localparam logic [2:0]  KEY_ADDR      = 3'd0;
  localparam logic [31:0] MAP_EDGE      = 32'd1024;
  localparam logic [31:0] PHASE_MASK    = 32'h1F;
  localparam logic [31:0] COL_STRIDE    = 32'd31;
  localparam logic [7:0]  VALUE_CEILING = 8'hA1;
  localparam logic [7:0]  VALUE_MARKER  = 8'hAB;

  logic [31:0] key_model;
  logic [31:0] running_model;
  logic [31:0] sums_due[$];

  // Negative keys land on row 0 only when the low five bits of the negation are
  // clear; anything else wraps far past the map edge
  function automatic logic [31:0] row_phase(input logic [31:0] k);
    logic [31:0] neg_low;
    neg_low = (32'd0 - k) & PHASE_MASK;
    if (!k[31]) return k & PHASE_MASK;
    return 32'd0 - neg_low;
  endfunction

  function automatic logic tile_counts(input logic [31:0] k, input logic [9:0] row,
                                       input logic [9:0] col, input logic [7:0] val);
    logic [31:0] rphase;
    logic        value_ok;
    rphase   = row_phase(k);
    value_ok = (val != 8'd0) && ((val < VALUE_CEILING) || (val == VALUE_MARKER));
    return (rphase < MAP_EDGE) && ((32'(row) & PHASE_MASK) == rphase) &&
           ((32'(col) % COL_STRIDE) == (k % COL_STRIDE)) && value_ok;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin : watch
    int          errors;
    logic [31:0] want;
    errors = 0;
    if (!rst_n) begin
      key_model     = 32'd0;
      running_model = 32'd0;
      sums_due.delete();
    end else begin
      // Compare a delivered sum with the oldest prediction
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          $display("%0t: map sum with nothing expected: expected none, actual %h",
                   $time, out_map_sum);
          errors++;
        end else begin
          want = sums_due.pop_front();
          if (out_map_sum !== want) begin
            $display("%0t: map_sum mismatch: expected %h, actual %h",
                     $time, want, out_map_sum);
            errors++;
          end
        end
      end
      // Accumulate an accepted tile; emit and restart on the last one
      if (in_valid && !in_stall) begin
        if (tile_counts(key_model, in_tile_row, in_tile_column, in_tile_value))
          running_model = running_model + (key_model ^ {24'd0, in_tile_value});
        if (in_last_tile) begin
          sums_due.push_back(running_model);
          running_model = key_model;
        end
      end
      // A key write starts a new map; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr == KEY_ADDR) begin
        key_model     = pwdata;
        running_model = pwdata;
      end
    end
    sums_pending <= sums_due.size();
    if (errors != 0) fail_count <= fail_count + errors;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Top of the strided map tile checksum testbench: clock, reset, key writes, tile
// stimulus, sum backpressure and the verdict. Uses map_sum_checker beside the block.
module tb;

  localparam logic [2:0]  KEY_ADDR       = 3'd0;
  localparam logic [2:0]  SPARE_ADDR     = 3'd4;
  localparam logic [31:0] PHASE_MASK     = 32'h1F;
  localparam logic [7:0]  VALUE_MARKER   = 8'hAB;
  localparam int          NUM_PHASES     = 12;
  localparam int          TILES_PER_MAP  = 115;
  localparam int          PRESSURE_PHASE = 4;
  localparam int          LONG_HOLD      = 300;
  localparam int          SETTLE_CYCLES  = 6;
  localparam logic [31:0] FIXED_KEYS [6] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                             32'hFFFF_FFE0, 32'h0000_001F, 32'h0000_0000};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_stall, in_last_tile;
  logic [9:0]  in_tile_row, in_tile_column;
  logic [7:0]  in_tile_value;
  logic        out_valid, out_stall;
  logic [31:0] out_map_sum;
  int          fail_count, sums_pending;
  logic        hold_phase = 1'b0;
  logic        hold_done = 1'b0;
  logic        quiet = 1'b0;
  logic [31:0] key_now = 32'd0;

  strided_map_tile_checksum dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_tile_row(in_tile_row), .in_tile_column(in_tile_column),
    .in_tile_value(in_tile_value), .in_last_tile(in_last_tile),
    .out_valid(out_valid), .out_stall(out_stall), .out_map_sum(out_map_sum)
  );

  map_sum_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_tile_row(in_tile_row), .in_tile_column(in_tile_column),
    .in_tile_value(in_tile_value), .in_last_tile(in_last_tile),
    .out_valid(out_valid), .out_stall(out_stall), .out_map_sum(out_map_sum),
    .fail_count(fail_count), .sums_pending(sums_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Setup phase, access phase held until pready, then the bus goes idle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one tile transaction and hold it until accepted
  task automatic send_tile(input logic [9:0] row, input logic [9:0] col,
                           input logic [7:0] val, input logic last);
    int gap;
    in_valid       <= 1'b1;
    in_tile_row    <= row;
    in_tile_column <= col;
    in_tile_value  <= val;
    in_last_tile   <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Most tiles sit on the key's row and column phase so they can count
  task automatic send_random_tile(input int last_odds, input logic force_last);
    logic [9:0]  row, col;
    logic [7:0]  val;
    logic [31:0] aim_row, aim_col;
    int          r;
    aim_row = key_now[31] ? 32'd0 : (key_now & PHASE_MASK);
    aim_col = key_now % 31;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      row = 10'(32 * $urandom_range(0, 31) + aim_row);
      col = 10'(31 * $urandom_range(0, (1023 - aim_col) / 31) + aim_col);
    end else begin
      row = 10'($urandom);
      col = 10'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 55) val = 8'($urandom_range(1, 160));
    else if (r < 65) val = VALUE_MARKER;
    else if (r < 72) val = 8'h00;
    else val = 8'($urandom);
    send_tile(row, col, val, force_last || ($urandom_range(1, last_odds) == 1));
  endtask

  // Drop valid, wait for every sum, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    // let the checker count the transaction taken at this edge
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sum side backpressure, plus one long hold-off to fill the block
  initial begin : receiver
    int span;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_phase && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] k;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= KEY_ADDR;
    pwdata         <= 32'd0;
    in_valid       <= 1'b0;
    in_tile_row    <= 10'd0;
    in_tile_column <= 10'd0;
    in_tile_value  <= 8'd0;
    in_last_tile   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key: value filter edges, a repeated tile, map corners, a bare last
    send_tile(10'd0,    10'd0,    8'h01, 1'b0);
    send_tile(10'd0,    10'd0,    8'h01, 1'b0);
    send_tile(10'd0,    10'd0,    8'h00, 1'b0);
    send_tile(10'd0,    10'd0,    8'hA0, 1'b0);
    send_tile(10'd0,    10'd0,    8'hA1, 1'b0);
    send_tile(10'd0,    10'd0,    8'hAA, 1'b0);
    send_tile(10'd0,    10'd0,    8'hAB, 1'b0);
    send_tile(10'd0,    10'd0,    8'hAC, 1'b0);
    send_tile(10'd0,    10'd0,    8'hFF, 1'b1);
    send_tile(10'd1023, 10'd1023, 8'h55, 1'b0);
    send_tile(10'd992,  10'd992,  8'h10, 1'b0);
    send_tile(10'd32,   10'd31,   8'h20, 1'b0);
    send_tile(10'd31,   10'd30,   8'h20, 1'b0);
    send_tile(10'd0,    10'd1023, 8'h7F, 1'b0);
    send_tile(10'd1023, 10'd0,    8'h7F, 1'b0);
    send_tile(10'd0,    10'd0,    8'h80, 1'b1);
    send_tile(10'd5,    10'd5,    8'h00, 1'b1);
    send_tile(10'd0,    10'd0,    8'hAB, 1'b1);
    drain();

    // One map per key, extremes first, then random keys
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 6) begin
        k = FIXED_KEYS[p];
      end else begin
        k = $urandom;
        if (p % 3 == 0) begin
          k[31]  = 1'b1;
          k[4:0] = 5'd0;
        end
      end
      key_now = k;
      write_reg(KEY_ADDR, k);
      if (p == 2) write_reg(SPARE_ADDR, $urandom);
      quiet = (p % 4 == 3);
      if (p == PRESSURE_PHASE) hold_phase <= 1'b1;
      for (int n = 0; n < TILES_PER_MAP; n++) begin
        send_random_tile((p == PRESSURE_PHASE) ? 2 : 16, 1'b0);
        if (p == 1 && n == TILES_PER_MAP / 2) drain();
      end
      send_random_tile(16, 1'b1);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
